// ===== hdl/dvdd_pkg.sv =====
`timescale 1ns / 1ps

package dvdd_pkg;

  localparam int DAY_W  = 6;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int NUM_W  = 23;
  localparam int DIST_W = 22;
  localparam int PROD_W = 27;
  localparam int Q_W    = 8;
  localparam int DBM_W  = 9;
  localparam int LEN_W  = 5;

  localparam int YEAR_MIN    = 1583;
  localparam int DAYS_YEAR   = 365;
  localparam int CENTURY     = 100;
  // floor(x / 100) == (x * 5243) >> 19 for every x below 43690.
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int MONTH_FEB   = 2;
  localparam int MONTH_DEC   = 12;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic rdy1;
    logic rdy2;
  } pipe_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
  } date_res_t;

  function automatic logic [DBM_W-1:0] days_before_month(input logic [MON_W-1:0] m);
    logic [DBM_W-1:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [LEN_W-1:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/dvdd_date.sv =====
`timescale 1ns / 1ps

module dvdd_date (
  input  logic                              clk,
  input  dvdd_pkg::pipe_ctrl_t              ctrl,
  input  logic [dvdd_pkg::DAY_W-1:0]        day,
  input  logic [dvdd_pkg::MON_W-1:0]        month,
  input  logic [dvdd_pkg::YEAR_W-1:0]       year,
  output dvdd_pkg::date_res_t               res
);

  localparam int YW = dvdd_pkg::YEAR_W;
  localparam int NW = dvdd_pkg::NUM_W;
  localparam int PW = dvdd_pkg::PROD_W;

  // First stage: the constant multiplications.
  logic [dvdd_pkg::DAY_W-1:0] d_r;
  logic [dvdd_pkg::MON_W-1:0] m_r;
  logic [YW-1:0]              y_r, l_r;
  logic [NW-1:0]              y365_r;
  logic [PW-1:0]              py_r, pl_r;

  logic [YW-1:0] l_nxt;
  logic          early;

  always_comb begin
    // January, February and month zero count leap years up to the year before.
    early = (month <= dvdd_pkg::MON_W'(dvdd_pkg::MONTH_FEB));
    if (early && (year != '0)) begin
      l_nxt = year - YW'(1);
    end else if (early) begin
      l_nxt = '0;
    end else begin
      l_nxt = year;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rdy1) begin
      d_r    <= day;
      m_r    <= month;
      y_r    <= year;
      l_r    <= l_nxt;
      y365_r <= NW'(year) * NW'(dvdd_pkg::DAYS_YEAR);
      py_r   <= PW'(year) * PW'(dvdd_pkg::RECIP_100);
      pl_r   <= PW'(l_nxt) * PW'(dvdd_pkg::RECIP_100);
    end
  end

  // Second stage: leap rule, validity and day number.
  logic [dvdd_pkg::Q_W-1:0]   q100y, q100l;
  logic [YW-1:0]              c100y;
  logic                       cent, leap, ok;
  logic [dvdd_pkg::LEN_W-1:0] len;
  logic [NW-1:0]              num;

  always_comb begin
    q100y = py_r[dvdd_pkg::RECIP_SHIFT +: dvdd_pkg::Q_W];
    q100l = pl_r[dvdd_pkg::RECIP_SHIFT +: dvdd_pkg::Q_W];
    c100y = YW'(q100y) * YW'(dvdd_pkg::CENTURY);
    cent  = (c100y == y_r);
    leap  = ((y_r[1:0] == 2'b00) && !cent) || (cent && (q100y[1:0] == 2'b00));
    len   = dvdd_pkg::month_len(m_r, leap);
    ok    = (y_r >= YW'(dvdd_pkg::YEAR_MIN)) && (m_r != '0) &&
            (m_r <= dvdd_pkg::MON_W'(dvdd_pkg::MONTH_DEC)) &&
            (d_r != '0) && (d_r <= dvdd_pkg::DAY_W'(len));
    num   = y365_r + NW'(d_r) + NW'(dvdd_pkg::days_before_month(m_r)) +
            NW'(l_r >> 2) - NW'(q100l) + NW'(q100l >> 2);
  end

  always_ff @(posedge clk) begin
    if (ctrl.rdy2) begin
      res.valid <= ok;
      res.num   <= num;
    end
  end

endmodule

// ===== hdl/dvdd_diff.sv =====
`timescale 1ns / 1ps

module dvdd_diff (
  input  logic                          clk,
  input  logic                          load,
  input  dvdd_pkg::date_res_t           first,
  input  dvdd_pkg::date_res_t           second,
  output logic [1:0]                    flags,
  output logic [dvdd_pkg::DIST_W-1:0]   days
);

  localparam int NW = dvdd_pkg::NUM_W;

  logic [NW-1:0]               diff;
  logic [dvdd_pkg::DIST_W-1:0] dist_nxt;
  logic [1:0]                  flags_r;
  logic [dvdd_pkg::DIST_W-1:0] dist_r;

  always_comb begin
    diff = (second.num >= first.num) ? (second.num - first.num)
                                     : (first.num - second.num);
    // Distances beyond the field saturate to all ones.
    if (diff > NW'(dvdd_pkg::DIST_MAX)) begin
      dist_nxt = dvdd_pkg::DIST_MAX;
    end else begin
      dist_nxt = diff[dvdd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags_r <= {second.valid, first.valid};
      dist_r  <= dist_nxt;
    end
  end

  assign flags = flags_r;
  assign days  = dist_r;

endmodule

// ===== hdl/date_validate_and_day_difference.sv =====
`timescale 1ns / 1ps

// Channel  Direction  tdata (low bit first)                      tuser
// in_      slave      day_first, month_first, year_first,        -
//                     day_second, month_second, year_second
// out_     master     days_between, two zero pad bits            first_valid, second_valid
//
// An accepted request reaches out_tvalid through the register stages below; one request
// is taken every cycle unless a stall on out_tready leaves every stage full.
// The depth is set by the three register stages: constant multiplications,
// date checks with day numbers, and the distance with its output register.
// rst_n clears only the stage valid bits; the data registers are not reset.
// A stall on out_tready holds a stage only while the stage after it is full,
// so bubbles close up and in_tready stays high while any stage is empty.

module date_validate_and_day_difference (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // day_first[5:0], month_first[9:6], year_first[23:10],
  // day_second[29:24], month_second[33:30], year_second[47:34]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // days_between[21:0], zeros[23:22]
  output logic [23:0] out_tdata,
  // first_valid[0], second_valid[1]
  output logic [1:0]  out_tuser
);

  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic rdy3;
  dvdd_pkg::pipe_ctrl_t ctrl;
  dvdd_pkg::date_res_t  res_first, res_second;
  logic [dvdd_pkg::DIST_W-1:0] days;

  always_comb begin
    rdy3      = !v3_r || out_tready;
    ctrl.rdy2 = !v2_r || rdy3;
    ctrl.rdy1 = !v1_r || ctrl.rdy2;
    v1_nxt    = ctrl.rdy1 ? in_tvalid : v1_r;
    v2_nxt    = ctrl.rdy2 ? v1_r : v2_r;
    v3_nxt    = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  dvdd_date u_date_first (
    .clk   (clk),
    .ctrl  (ctrl),
    .day   (in_tdata[5:0]),
    .month (in_tdata[9:6]),
    .year  (in_tdata[23:10]),
    .res   (res_first)
  );

  dvdd_date u_date_second (
    .clk   (clk),
    .ctrl  (ctrl),
    .day   (in_tdata[29:24]),
    .month (in_tdata[33:30]),
    .year  (in_tdata[47:34]),
    .res   (res_second)
  );

  dvdd_diff u_diff (
    .clk    (clk),
    .load   (rdy3),
    .first  (res_first),
    .second (res_second),
    .flags  (out_tuser),
    .days   (days)
  );

  assign in_tready  = ctrl.rdy1;
  assign out_tvalid = v3_r;
  assign out_tdata  = {2'b00, days};

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted request did not enter the first stage");

  a_first_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !ctrl.rdy2) |=> v1_r)
    else $error("first stage lost a request while the next stage was full");

  a_second_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && rdy3) |=> out_tvalid)
    else $error("second stage advanced without reaching the output");

  a_ready_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r || !v2_r || !v3_r) |-> in_tready)
    else $error("input stalled although a stage was empty");
`endif

endmodule
